@@ src/tfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned POS_W       = 4;

  localparam logic [POS_W-1:0] POS_HUNT      = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR2      = POS_W'(1);
  localparam logic [POS_W-1:0] POS_DIST_LO   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_DIST_MID  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_DIST_HI   = POS_W'(10);
  localparam logic [POS_W-1:0] POS_STATUS    = POS_W'(11);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

  // widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned RES_TDATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h57;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h00;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_UPDATED    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_BAD_SUM    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_BAD_STATUS = 2'd2;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [DIST_W-1:0]    distance;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } headers_t;

endpackage

`default_nettype wire

@@ src/tfp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tfp_parser (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     accept,
  input  wire [tfp_pkg::BYTE_W-1:0] rx_byte,
  input  tfp_pkg::headers_t       headers,
  output tfp_pkg::result_req_t    result
);
  import tfp_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_next;
  logic [BYTE_W-1:0] sum_plus;
  logic [DIST_W-1:0] captured_distance;
  logic [BYTE_W-1:0] captured_status;
  logic [DIST_W-1:0] held_distance;
  logic [DIST_W-1:0] held_distance_next;
  logic              frame_end;

  assign sum_plus  = running_sum + rx_byte;
  assign frame_end = accept && (pos == POS_LAST);

  always_comb begin
    pos_next           = pos;
    running_sum_next   = running_sum;
    held_distance_next = held_distance;
    result.valid       = frame_end;
    result.res.outcome = OUT_UPDATED;
    if (accept) begin
      if (pos == POS_HUNT) begin
        if (rx_byte == headers.first) begin
          running_sum_next = rx_byte;
          pos_next         = POS_HDR2;
        end
      end else if (pos == POS_HDR2) begin
        // a bad second header is dropped, not retried as a first header
        if (rx_byte == headers.second) begin
          running_sum_next = sum_plus;
          pos_next         = pos + POS_W'(1);
        end else begin
          pos_next = POS_HUNT;
        end
      end else if (pos != POS_LAST) begin
        running_sum_next = sum_plus;
        pos_next         = pos + POS_W'(1);
      end else begin
        pos_next = POS_HUNT;
        if (rx_byte != running_sum) begin
          result.res.outcome = OUT_BAD_SUM;
        end else if (captured_status != '0) begin
          result.res.outcome = OUT_BAD_STATUS;
        end else begin
          held_distance_next = captured_distance;
        end
      end
    end
    result.res.distance = held_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= POS_HUNT;
      running_sum   <= '0;
      held_distance <= '0;
    end else begin
      pos           <= pos_next;
      running_sum   <= running_sum_next;
      held_distance <= held_distance_next;
    end
  end

  // payload captures, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos)
        POS_DIST_LO:  captured_distance[7:0]   <= rx_byte;
        POS_DIST_MID: captured_distance[15:8]  <= rx_byte;
        POS_DIST_HI:  captured_distance[23:16] <= rx_byte;
        POS_STATUS:   captured_status          <= rx_byte;
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LAST)
    else $error("frame position past last byte");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> pos == POS_HUNT)
    else $error("parser did not return to hunting after frame end");

  a_held_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !(result.valid && result.res.outcome == OUT_UPDATED) |=> $stable(held_distance))
    else $error("held distance changed without a good frame");

endmodule

`default_nettype wire

@@ src/tfp_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tfp_out_buf (
  input  wire                         clk,
  input  wire                         rst,
  input  tfp_pkg::result_req_t        push,
  output logic                        space,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output tfp_pkg::result_t            m_res
);
  import tfp_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    pop;

  assign pop   = m_tvalid && m_tready;
  // ready is registered: room as long as the skid slot is empty
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      m_tvalid   <= skid_valid || push.valid;
      skid_valid <= 1'b0;
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || pop) begin
      m_res <= skid_valid ? skid_res : push.res;
    end
    if (push.valid && !skid_valid) begin
      skid_res <= push.res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid slot full while output empty");

  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !pop |=> skid_valid)
    else $error("skid entry lost");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push.valid)
    else $error("result pushed into full buffer");

endmodule

`default_nettype wire

@@ src/tof_frame_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake            | Payload
// s_*       | in  | s_tvalid / s_tready  | s_tdata[7:0] rx_byte
// m_*       | out | m_tvalid / m_tready  | m_tdata[23:0] distance, [25:24] outcome
// cfg_*     | in  | cfg_valid / cfg_ready| cfg_index (0 header_first, 1 header_second),
//           |     |                      | cfg_data[7:0]
//
// One received byte is taken per cycle while s_tready is high; a frame-end
// byte's result is registered into m_tdata, or into the skid slot if held.
// A two-slot output buffer (output register plus skid slot) lets input flow
// continue while a result waits; s_tready drops only when both slots hold.
// Reset (rst, synchronous) restarts header hunting, clears the running sum
// and the held distance, and loads headers 0x57 / 0x00.
// cfg_ready is always high; a header write applies to the next header compare.

module tof_frame_parser_unit (
  input  wire        clk,
  input  wire        rst,
  // received bytes
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] rx_byte
  // frame results
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [31:0] m_tdata,  // [23:0] distance, [25:24] outcome, rest zero
  // register writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [tfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [7:0]  cfg_data
);
  import tfp_pkg::*;

  headers_t    headers;
  result_req_t result;
  result_t     out_res;
  logic        accept;
  logic        space;

  assign cfg_ready = 1'b1;
  assign s_tready  = space;
  assign accept    = s_tvalid && s_tready;

  // header registers
  always_ff @(posedge clk) begin
    if (rst) begin
      headers.first  <= HEADER_FIRST_RST;
      headers.second <= HEADER_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_FIRST:  headers.first  <= cfg_data;
        REG_HEADER_SECOND: headers.second <= cfg_data;
        default: ;
      endcase
    end
  end

  tfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .headers (headers),
    .result  (result)
  );

  tfp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (result),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (out_res)
  );

  assign m_tdata = {{(RES_TDATA_W - DIST_W - OUTCOME_W){1'b0}},
                    out_res.outcome, out_res.distance};

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.outcome == OUT_UPDATED || out_res.outcome == OUT_BAD_SUM ||
                  out_res.outcome == OUT_BAD_STATUS))
    else $error("illegal outcome code on output");

endmodule

`default_nettype wire
